// ----- rtl/lmsc_pkg.sv -----
// Shared types, codes and geometry helpers for the LED matrix scan controller.
// Used by the frame store, the scan sequencer, the top level and the testbench; depends on nothing else.
`default_nettype none

package lmsc_pkg;

    localparam int FRAME_BYTES_DEF = 1024;

    // Command codes carried by an input word.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SHIFT = 2'd1;
    localparam logic [1:0] CMD_SWAP  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PANEL_KIND    = 3'd0;
    localparam logic [2:0] CFG_PANELS_ACROSS = 3'd1;
    localparam logic [2:0] CFG_PANELS_DOWN   = 3'd2;
    localparam logic [2:0] CFG_PANEL_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_PANEL_HEIGHT  = 3'd4;
    localparam logic [2:0] CFG_BRIGHTNESS    = 3'd5;
    localparam logic [2:0] CFG_DOUBLE_BUFFER = 3'd6;

    // Canvas geometry derived from the size registers.
    typedef struct packed {
        logic [7:0] stride;   // bytes per canvas row, 1..128
        logic [8:0] height;   // canvas rows, 1..256
        logic [4:0] units12;  // 16-row bands for quarter scan
        logic [3:0] units08;  // 32-row groups for sixteenth scan
    } t_geom;

    // One shift step as seen by the datapath.
    typedef struct packed {
        logic [7:0] row;
        logic [6:0] col;
        logic       rev;       // bit-reverse the fetched byte
        logic       inv;       // invert the fetched byte
        logic       last;      // last byte of the scan line
        logic [3:0] row_addr;  // scan row shown with the latch
    } t_step;

    function automatic t_geom geom_calc(input logic       kind,
                                        input logic [3:0] pa,
                                        input logic [2:0] pd,
                                        input logic [7:0] pw,
                                        input logic [6:0] ph);
        logic [3:0]  pa_s;
        logic [2:0]  pd_s;
        logic [7:0]  pw_s;
        logic [6:0]  ph_s;
        logic [10:0] width;
        logic [8:0]  height;
        t_geom       g;
        pa_s = (pa == 4'd0) ? 4'd1 : ((pa > 4'd8) ? 4'd8 : pa);
        pd_s = (pd == 3'd0) ? 3'd1 : ((pd > 3'd4) ? 3'd4 : pd);
        pw_s = (pw > 8'd128) ? 8'd128 : pw;
        ph_s = (ph > 7'd64) ? 7'd64 : ph;
        if (pw_s == 8'd0 || ph_s == 7'd0) begin
            pw_s = kind ? 8'd64 : 8'd32;
            ph_s = 7'd16;
        end
        width     = {7'd0, pa_s} * {3'd0, pw_s};
        height    = {6'd0, pd_s} * {2'd0, ph_s};
        g.stride  = 8'(({1'b0, width} + 12'd7) >> 3);
        g.height  = height;
        g.units12 = 5'(({1'b0, height} + 10'd15) >> 4);
        g.units08 = 4'(({1'b0, height} + 10'd31) >> 5);
        return g;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lmsc_frame_ram.sv -----
// One framebuffer byte store: one write port and one registered read port.
// Uses lmsc_pkg for the default depth.
`default_nettype none

module lmsc_frame_ram
    import lmsc_pkg::*;
#(
    parameter int DEPTH = FRAME_BYTES_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lmsc_scan_seq.sv -----
// Scan position counters: phase, band, column and subrow, stepped once per shift.
// Uses lmsc_pkg for the geometry and step structs.
`default_nettype none

module lmsc_scan_seq
    import lmsc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_geom i_geom,
    input  wire logic  i_kind,
    input  wire logic  i_step,
    input  wire logic  i_restart,
    output t_step      o_step
);

    logic [3:0] r_phase, n_phase;
    logic [3:0] r_band, n_band;
    logic [6:0] r_col, n_col;
    logic [1:0] r_sub, n_sub;
    logic       r_flip, n_flip;

    logic       w_wrap;
    logic [3:0] w_b;
    logic [6:0] w_c;
    logic [1:0] w_s;
    logic [1:0] w_p;
    logic       w_flip;
    logic       w_col_last;
    logic       w_band_last;
    logic       w_last;

    always_comb begin
        // Counters that fall outside the current geometry restart the line.
        if (i_kind) begin
            w_wrap = ({1'b0, r_col} >= i_geom.stride) || (r_band >= i_geom.units08);
        end else begin
            w_wrap = ({1'b0, r_col} >= i_geom.stride) || ({1'b0, r_band} >= i_geom.units12);
        end
        w_b = w_wrap ? 4'd0 : r_band;
        w_c = w_wrap ? 7'd0 : r_col;
        w_s = w_wrap ? 2'd0 : r_sub;
        w_p = r_phase[1:0];

        w_col_last = (({1'b0, w_c} + 8'd1) == i_geom.stride);
        if (i_kind) begin
            w_band_last = (({1'b0, w_b} + 5'd1) == {1'b0, i_geom.units08});
        end else begin
            w_band_last = (({1'b0, w_b} + 5'd1) == i_geom.units12);
        end

        // A quarter-scan line starts on the band type chosen by height bit 4.
        if (w_b == 4'd0 && w_c == 7'd0 && w_s == 2'd0) begin
            w_flip = ~i_geom.height[4];
        end else begin
            w_flip = r_flip;
        end

        n_phase = r_phase;
        n_band  = w_b;
        n_col   = w_c;
        n_sub   = w_s;
        n_flip  = r_flip;

        if (i_kind) begin
            w_last          = w_band_last && w_col_last;
            o_step.row      = {w_b[2:0], 1'b0, r_phase};
            o_step.col      = w_c;
            o_step.rev      = 1'b0;
            o_step.inv      = 1'b1;
            o_step.row_addr = r_phase;
            if (w_col_last) begin
                n_col  = 7'd0;
                n_band = w_band_last ? 4'd0 : w_b + 4'd1;
            end else begin
                n_col = w_c + 7'd1;
            end
            if (w_last) begin
                n_phase = r_phase + 4'd1;
            end
        end else begin
            w_last = w_band_last && w_col_last && (w_s == 2'd3);
            // Plain bands walk rows +12, +8, +4, +0; flipped bands the mirror order.
            if (w_flip) begin
                o_step.row = {w_b, w_s, ~w_p};
                o_step.col = 7'(i_geom.stride - 8'd1 - {1'b0, w_c});
            end else begin
                o_step.row = {w_b, ~w_s, w_p};
                o_step.col = w_c;
            end
            o_step.rev      = w_flip;
            o_step.inv      = 1'b0;
            o_step.row_addr = {2'b00, w_p};
            n_flip          = w_flip;
            n_sub           = w_s + 2'd1;
            if (w_s == 2'd3) begin
                if (w_col_last) begin
                    n_col  = 7'd0;
                    n_flip = ~w_flip;
                    n_band = w_band_last ? 4'd0 : w_b + 4'd1;
                end else begin
                    n_col = w_c + 7'd1;
                end
            end
            if (w_last) begin
                n_phase = {2'b00, w_p + 2'd1};
            end
        end
        o_step.last = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 4'd0;
            r_band  <= 4'd0;
            r_col   <= 7'd0;
            r_sub   <= 2'd0;
            r_flip  <= 1'b0;
        end else if (i_restart) begin
            r_band <= 4'd0;
            r_col  <= 7'd0;
            r_sub  <= 2'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_band  <= n_band;
            r_col   <= n_col;
            r_sub   <= n_sub;
            r_flip  <= n_flip;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/led_matrix_scan_controller_unit.sv -----
// LED matrix scan controller: framebuffer writes, buffer swaps and shift steps.
// A shift word passes stage 1, the store read and the result register.
// Throughput: one word per cycle unless stalled; one registered read port per store.
// Reset: configuration and counters return to defaults, then a clearing pass over
// every address fills both stores with 0xFF; enabling double buffering runs the
// same pass over store b. No input word is accepted during a pass.
`default_nettype none

module led_matrix_scan_controller_unit
    import lmsc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Input words.
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [9:0] i_byte_address,
    input  wire logic [7:0] i_write_byte,
    // Result words.
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_shift_byte,
    output logic            o_latch_now,
    output logic      [3:0] o_row_address,
    output logic      [7:0] o_oe_duty,
    // Configuration writes.
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(FRAME_BYTES);

    // ------------------------------------------------------------------
    // Configuration registers. The geometry is recomputed from the next
    // register values so it is current on the cycle after a write. The
    // canvas area, used by the write check, is registered from that geometry.
    // ------------------------------------------------------------------
    logic       r_kind, n_kind;
    logic [3:0] r_pa, n_pa;
    logic [2:0] r_pd, n_pd;
    logic [7:0] r_pw, n_pw;
    logic [6:0] r_ph, n_ph;
    logic [7:0] r_bright, n_bright;
    logic       r_dbl, n_dbl;
    t_geom      r_geom;
    logic [15:0] r_area;

    logic w_cfg_acc;
    logic w_cfg_restart;
    logic w_dbl_enable;
    logic w_dbl_disable;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_kind        = r_kind;
        n_pa          = r_pa;
        n_pd          = r_pd;
        n_pw          = r_pw;
        n_ph          = r_ph;
        n_bright      = r_bright;
        n_dbl         = r_dbl;
        w_cfg_restart = 1'b0;
        if (w_cfg_acc) begin
            unique case (i_cfg_index)
                CFG_PANEL_KIND: begin
                    n_kind        = i_cfg_data[0];
                    w_cfg_restart = 1'b1;
                end
                CFG_PANELS_ACROSS: begin
                    n_pa          = i_cfg_data[3:0];
                    w_cfg_restart = 1'b1;
                end
                CFG_PANELS_DOWN: begin
                    n_pd          = i_cfg_data[2:0];
                    w_cfg_restart = 1'b1;
                end
                CFG_PANEL_WIDTH: begin
                    n_pw          = i_cfg_data;
                    w_cfg_restart = 1'b1;
                end
                CFG_PANEL_HEIGHT: begin
                    n_ph          = i_cfg_data[6:0];
                    w_cfg_restart = 1'b1;
                end
                CFG_BRIGHTNESS: begin
                    n_bright = i_cfg_data;
                end
                CFG_DOUBLE_BUFFER: begin
                    n_dbl = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
        // Only a change of the double buffer bit has an effect.
        w_dbl_enable  = n_dbl && !r_dbl;
        w_dbl_disable = !n_dbl && r_dbl;
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control.
    // Stage 1 holds an accepted write or shift word. Stage 2 is the store
    // read (its data sits in the RAM output register). Stage 3 is the result
    // register. Writes retire out of stage 1, in order with the reads.
    // ------------------------------------------------------------------
    logic w_in_acc;
    logic w_sweeping;
    logic w_s1_load;
    logic w_s1_go;
    logic w_s2_load;
    logic w_s2_free;
    logic w_s3_load;
    logic w_shift_acc;
    logic w_swap_acc;

    logic r_s1_valid;
    logic r_s2_valid;

    assign w_s3_load   = !o_out_valid || i_out_ready;
    assign w_s2_free   = !r_s2_valid || w_s3_load;
    assign o_in_ready  = !w_sweeping && (!r_s1_valid || w_s1_go);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_shift_acc = w_in_acc && (i_command == CMD_SHIFT);
    assign w_swap_acc  = w_in_acc && (i_command == CMD_SWAP);
    assign w_s1_load   = w_in_acc && ((i_command == CMD_WRITE) || (i_command == CMD_SHIFT));

    // ------------------------------------------------------------------
    // Scan position.
    // ------------------------------------------------------------------
    t_step w_step;

    lmsc_scan_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (r_geom),
        .i_kind    (r_kind),
        .i_step    (w_shift_acc),
        .i_restart (w_cfg_restart),
        .o_step    (w_step)
    );

    // ------------------------------------------------------------------
    // Buffer select and clearing pass. r_draw_sel set means drawing goes
    // into store b; with double buffering on, the other store is shown.
    // ------------------------------------------------------------------
    logic          r_draw_sel;
    logic          r_clr_a;
    logic          r_clr_b;
    logic [AW-1:0] r_clr_cnt;

    assign w_sweeping = r_clr_a || r_clr_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= 1'b0;
            r_pa       <= 4'd1;
            r_pd       <= 3'd1;
            r_pw       <= 8'd0;
            r_ph       <= 7'd0;
            r_bright   <= 8'd255;
            r_dbl      <= 1'b0;
            r_geom     <= geom_calc(1'b0, 4'd1, 3'd1, 8'd0, 7'd0);
            r_area     <= 16'd64;
            r_draw_sel <= 1'b0;
            r_clr_a    <= 1'b1;
            r_clr_b    <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            r_kind   <= n_kind;
            r_pa     <= n_pa;
            r_pd     <= n_pd;
            r_pw     <= n_pw;
            r_ph     <= n_ph;
            r_bright <= n_bright;
            r_dbl    <= n_dbl;
            r_geom   <= geom_calc(n_kind, n_pa, n_pd, n_pw, n_ph);
            r_area   <= {8'd0, r_geom.stride} * {7'd0, r_geom.height};

            if (w_dbl_enable) begin
                r_draw_sel <= 1'b1;
            end else if (w_dbl_disable) begin
                r_draw_sel <= 1'b0;
            end else if (w_swap_acc && r_dbl) begin
                r_draw_sel <= ~r_draw_sel;
            end

            if (w_dbl_enable) begin
                // A fresh enable restarts the pass; store b then runs its full length.
                if (r_clr_cnt == AW'(FRAME_BYTES - 1)) begin
                    r_clr_a <= 1'b0;
                end
                r_clr_b   <= 1'b1;
                r_clr_cnt <= '0;
            end else if (w_sweeping) begin
                if (r_clr_cnt == AW'(FRAME_BYTES - 1)) begin
                    r_clr_a <= 1'b0;
                    r_clr_b <= 1'b0;
                end
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the accepted word. A write remembers the draw store, a shift
    // remembers the display store, both as they stand at acceptance.
    // ------------------------------------------------------------------
    logic       r_s1_write;
    logic       r_s1_sel;
    logic [9:0] r_s1_addr;
    logic [7:0] r_s1_data;
    logic [7:0] r_s1_row;
    logic [6:0] r_s1_col;
    logic       r_s1_rev;
    logic       r_s1_inv;
    logic       r_s1_last;
    logic [3:0] r_s1_raddr;
    logic [7:0] r_s1_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_write <= (i_command == CMD_WRITE);
            r_s1_sel   <= (i_command == CMD_WRITE) ? r_draw_sel : (r_dbl && !r_draw_sel);
            r_s1_addr  <= i_byte_address;
            r_s1_data  <= i_write_byte;
            r_s1_row   <= w_step.row;
            r_s1_col   <= w_step.col;
            r_s1_rev   <= w_step.rev;
            r_s1_inv   <= w_step.inv;
            r_s1_last  <= w_step.last;
            r_s1_raddr <= w_step.last ? w_step.row_addr : 4'd0;
            if (w_step.last) begin
                r_s1_duty <= r_kind ? ~r_bright : r_bright;
            end else begin
                r_s1_duty <= 8'd0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 to 2: byte index, range checks, store write or read.
    // ------------------------------------------------------------------
    logic [16:0]   w_idx;
    logic          w_rd_ok;
    logic          w_wr_ok;
    logic          w_wr_en;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata_a;
    logic [7:0]    w_rdata_b;

    assign w_s1_go   = r_s1_valid && !w_sweeping && (r_s1_write || w_s2_free);
    assign w_s2_load = w_s1_go && !r_s1_write;

    assign w_idx   = 17'({9'd0, r_s1_row} * {9'd0, r_geom.stride}) + {10'd0, r_s1_col};
    // Rows past the canvas and indexes past the store read as blank.
    assign w_rd_ok = ({1'b0, r_s1_row} < r_geom.height)
                     && ({15'd0, w_idx} < 32'(FRAME_BYTES));
    // Writes outside the canvas or the store are dropped.
    assign w_wr_ok = ({6'd0, r_s1_addr} < r_area)
                     && ({22'd0, r_s1_addr} < 32'(FRAME_BYTES));
    assign w_wr_en = w_s1_go && r_s1_write && w_wr_ok;

    assign w_waddr = w_sweeping ? r_clr_cnt : AW'(r_s1_addr);
    assign w_wdata = w_sweeping ? 8'hFF : r_s1_data;
    assign w_raddr = AW'(w_idx);

    lmsc_frame_ram #(
        .DEPTH (FRAME_BYTES)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (r_clr_a || (w_wr_en && !r_s1_sel)),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_s2_load),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_a)
    );

    lmsc_frame_ram #(
        .DEPTH (FRAME_BYTES)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (r_clr_b || (w_wr_en && r_s1_sel)),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_s2_load),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_b)
    );

    // ------------------------------------------------------------------
    // Stage 2: side information that travels with the read data.
    // ------------------------------------------------------------------
    logic       r_s2_sel;
    logic       r_s2_blank;
    logic       r_s2_rev;
    logic       r_s2_inv;
    logic       r_s2_last;
    logic [3:0] r_s2_raddr;
    logic [7:0] r_s2_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_s2_valid <= 1'b1;
        end else if (w_s3_load) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_s2_sel   <= r_s1_sel;
            r_s2_blank <= !w_rd_ok;
            r_s2_rev   <= r_s1_rev;
            r_s2_inv   <= r_s1_inv;
            r_s2_last  <= r_s1_last;
            r_s2_raddr <= r_s1_raddr;
            r_s2_duty  <= r_s1_duty;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: result register. Flipped bands send the byte bit-reversed,
    // sixteenth-scan panels take it inverted.
    // ------------------------------------------------------------------
    logic [7:0] w_fetch;
    logic [7:0] w_ordered;
    logic [7:0] w_byte;

    assign w_fetch   = r_s2_blank ? 8'hFF : (r_s2_sel ? w_rdata_b : w_rdata_a);
    assign w_ordered = r_s2_rev ? rev8(w_fetch) : w_fetch;
    assign w_byte    = r_s2_inv ? ~w_ordered : w_ordered;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_s3_load) begin
            o_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_load && r_s2_valid) begin
            o_shift_byte  <= w_byte;
            o_latch_now   <= r_s2_last;
            o_row_address <= r_s2_raddr;
            o_oe_duty     <= r_s2_duty;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lmsc_checker.sv -----
// Port-level checks for the LED matrix scan controller, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module lmsc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_shift_byte,
    input wire logic       o_latch_now,
    input wire logic [3:0] o_row_address,
    input wire logic [7:0] o_oe_duty
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && o_in_ready;

    // A result word that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_shift_byte) && $stable(o_latch_now)
            && $stable(o_row_address) && $stable(o_oe_duty))
        else $error("result word changed or dropped while stalled");

    // The clearing pass after reset keeps input words out.
    a_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_in_ready)
        else $error("input accepted during the clearing pass");

    // With the result register empty, a result can appear only from an accepted
    // word that has passed through stage 1 and the store read.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n, 2) && $past(i_rst_n, 1) && !o_out_valid && !$past(w_in_acc, 2)
            |=> !o_out_valid)
        else $error("result word without a matching input word");

endmodule

bind led_matrix_scan_controller_unit lmsc_checker u_lmsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_shift_byte  (o_shift_byte),
    .o_latch_now   (o_latch_now),
    .o_row_address (o_row_address),
    .o_oe_duty     (o_oe_duty)
);

`default_nettype wire

// ----- tb/led_matrix_scan_controller_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the LED matrix scan controller top level.
// Depends on lmsc_pkg and led_matrix_scan_controller_unit, with the modules that unit uses.

module led_matrix_scan_controller_unit_test;
    import lmsc_pkg::*;

    localparam real        HALF_PERIOD   = 2.0;
    localparam int         FRAME_BYTES   = FRAME_BYTES_DEF;
    // The block answers a shift word through its pipeline stages; this pad covers that
    // and any write still in flight when the last result word has come.
    localparam int         SETTLE_CYCLES = 8;
    // The limit sits far above the slowest correct run (gaps, stalls, clearing passes).
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         RANDOM_ITEMS  = 1750;
    localparam int         REPORT_CAP    = 40;
    localparam logic [1:0] CMD_UNKNOWN   = 2'd3;

    // One result word as the panel sees it.
    typedef struct packed {
        logic [7:0] shift_byte;
        logic       latch_now;
        logic [3:0] row_address;
        logic [7:0] oe_duty;
    } scan_word_t;

    // Clock, reset and the block's ports. Every input starts at a known value.
    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [1:0] i_command      = CMD_WRITE;
    logic [9:0] i_byte_address = '0;
    logic [7:0] i_write_byte   = '0;
    logic       i_out_ready    = 1'b0;
    logic       i_cfg_valid    = 1'b0;
    logic [2:0] i_cfg_index    = CFG_PANEL_KIND;
    logic [7:0] i_cfg_data     = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_shift_byte;
    logic       o_latch_now;
    logic [3:0] o_row_address;
    logic [7:0] o_oe_duty;
    logic       o_cfg_ready;

    led_matrix_scan_controller_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_byte_address (i_byte_address),
        .i_write_byte   (i_write_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_shift_byte   (o_shift_byte),
        .o_latch_now    (o_latch_now),
        .o_row_address  (o_row_address),
        .o_oe_duty      (o_oe_duty),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: shadow registers, both pixel stores and the scan
    // counters, kept at the widths the block uses.
    // ------------------------------------------------------------------
    logic       kind_q;
    logic [3:0] across_q;
    logic [2:0] down_q;
    logic [7:0] width_q;
    logic [6:0] height_q;
    logic [7:0] bright_q;
    logic       dbuf_q;

    logic [7:0] pixels_a [FRAME_BYTES];
    logic [7:0] pixels_b [FRAME_BYTES];
    logic [3:0] row_phase;
    logic [3:0] band_pos;
    logic [6:0] col_pos;
    logic [1:0] sub_pos;
    logic       band_mirror;
    logic       draw_b;

    scan_word_t expected_words [$];
    scan_word_t got_word;
    scan_word_t want_word;
    int         error_count = 0;
    int         cycle_count = 0;

    // Sender bookkeeping: how many words remain in the current burst and
    // whether valid is currently raised.
    int         burst_left  = 0;
    logic       in_raised   = 1'b0;

    // Receiver stall pattern state.
    int         rx_mode     = 0;
    int         mode_left   = 0;
    int         hold_left   = 0;

    task automatic reset_predictor();
        kind_q      = 1'b0;
        across_q    = 4'd1;
        down_q      = 3'd1;
        width_q     = 8'd0;
        height_q    = 7'd0;
        bright_q    = 8'd255;
        dbuf_q      = 1'b0;
        row_phase   = '0;
        band_pos    = '0;
        col_pos     = '0;
        sub_pos     = '0;
        band_mirror = 1'b0;
        draw_b      = 1'b0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            pixels_a[i] = 8'hFF;
            pixels_b[i] = 8'hFF;
        end
    endtask

    // Canvas geometry from the shadow size registers, with saturation and
    // the default for the panel kind when either panel size is zero.
    task automatic canvas_geometry(output int stride, output int height);
        int pa;
        int pd;
        int pw;
        int ph;
        pa = across_q;
        pd = down_q;
        pw = width_q;
        ph = height_q;
        if (pa < 1) pa = 1;
        if (pa > 8) pa = 8;
        if (pd < 1) pd = 1;
        if (pd > 4) pd = 4;
        if (pw > 128) pw = 128;
        if (ph > 64) ph = 64;
        if (pw == 0 || ph == 0) begin
            pw = kind_q ? 64 : 32;
            ph = 16;
        end
        stride = (pa * pw + 7) / 8;
        height = pd * ph;
    endtask

    function automatic logic [7:0] mirror_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    // The byte the display store holds at a canvas position; anything off
    // the canvas or past the store reads as blank.
    function automatic logic [7:0] shown_byte(input int row, input int col,
                                              input int stride, input int height);
        int idx;
        if (row >= height) return 8'hFF;
        idx = row * stride + col;
        if (idx >= FRAME_BYTES) return 8'hFF;
        if (dbuf_q && !draw_b) return pixels_b[idx];
        return pixels_a[idx];
    endfunction

    function automatic void restart_scan_line();
        band_pos = '0;
        col_pos  = '0;
        sub_pos  = '0;
    endfunction

    task automatic apply_register(input logic [2:0] idx, input logic [7:0] value);
        case (idx)
            CFG_PANEL_KIND: begin
                kind_q = value[0];
                restart_scan_line();
            end
            CFG_PANELS_ACROSS: begin
                across_q = value[3:0];
                restart_scan_line();
            end
            CFG_PANELS_DOWN: begin
                down_q = value[2:0];
                restart_scan_line();
            end
            CFG_PANEL_WIDTH: begin
                width_q = value;
                restart_scan_line();
            end
            CFG_PANEL_HEIGHT: begin
                height_q = value[6:0];
                restart_scan_line();
            end
            CFG_BRIGHTNESS: begin
                bright_q = value;
            end
            CFG_DOUBLE_BUFFER: begin
                // Rewriting the current value changes nothing.
                if (value[0] != dbuf_q) begin
                    dbuf_q = value[0];
                    draw_b = value[0];
                    if (value[0]) begin
                        for (int i = 0; i < FRAME_BYTES; i++) pixels_b[i] = 8'hFF;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Works out the next panel byte and advances the scan counters.
    task automatic scan_next_byte(input int stride, input int height);
        scan_word_t w;
        int         units;
        int         p;
        int         y;
        int         s;
        logic       last;
        if (kind_q) begin
            // Sixteenth scan: one row per 32-row group, sent inverted.
            units = (height + 31) / 32;
            if (col_pos >= stride || band_pos >= units) restart_scan_line();
            w.shift_byte = ~shown_byte(band_pos * 32 + row_phase, col_pos, stride, height);
            last = (band_pos + 1 == units) && (col_pos + 1 == stride);
            w.latch_now   = last;
            w.row_address = last ? row_phase : 4'd0;
            w.oe_duty     = last ? 8'(255 - bright_q) : 8'd0;
            if (col_pos + 1 >= stride) begin
                col_pos = '0;
                if (band_pos + 1 >= units) band_pos = '0;
                else band_pos = band_pos + 1;
            end else begin
                col_pos = col_pos + 1;
            end
            if (last) row_phase = row_phase + 1;
        end else begin
            // Quarter scan: four rows per column, bands alternate between a
            // plain left-to-right pass and a mirrored right-to-left pass.
            p     = row_phase[1:0];
            units = (height + 15) / 16;
            if (col_pos >= stride || band_pos >= units) restart_scan_line();
            if (band_pos == 0 && col_pos == 0 && sub_pos == 0) begin
                band_mirror = ((height & 16) == 0);
            end
            y = band_pos * 16;
            s = sub_pos;
            if (!band_mirror) begin
                w.shift_byte = shown_byte(y + p + 12 - 4 * s, col_pos, stride, height);
            end else begin
                w.shift_byte = mirror_byte(shown_byte(y + 3 - p + 4 * s,
                                                      stride - 1 - col_pos, stride, height));
            end
            last = (band_pos + 1 == units) && (col_pos + 1 == stride) && (sub_pos == 2'd3);
            w.latch_now   = last;
            w.row_address = last ? 4'(p) : 4'd0;
            w.oe_duty     = last ? bright_q : 8'd0;
            if (sub_pos == 2'd3) begin
                sub_pos = '0;
                if (col_pos + 1 >= stride) begin
                    col_pos     = '0;
                    band_mirror = ~band_mirror;
                    if (band_pos + 1 >= units) band_pos = '0;
                    else band_pos = band_pos + 1;
                end else begin
                    col_pos = col_pos + 1;
                end
            end else begin
                sub_pos = sub_pos + 1;
            end
            if (last) row_phase = 4'((p + 1) & 3);
        end
        expected_words.push_back(w);
    endtask

    // Updates the predictor for one accepted input word.
    task automatic predict_word(input logic [1:0] cmd, input logic [9:0] addr,
                                input logic [7:0] data);
        int stride;
        int height;
        canvas_geometry(stride, height);
        case (cmd)
            CMD_WRITE: begin
                // Writes off the canvas or past the store are dropped.
                if (addr < stride * height && addr < FRAME_BYTES) begin
                    if (draw_b) pixels_b[addr] = data;
                    else pixels_a[addr] = data;
                end
            end
            CMD_SWAP: begin
                if (dbuf_q) draw_b = ~draw_b;
            end
            CMD_SHIFT: begin
                scan_next_byte(stride, height);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Sends one input word. Words go out in bursts; valid is only lowered
    // at the end of a burst, and the gap that follows waits on the clock,
    // so valid never drops and rises within one time step.
    task automatic send_word(input logic [1:0] cmd, input logic [9:0] addr,
                             input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            if (in_raised) begin
                i_in_valid <= 1'b0;
                in_raised = 1'b0;
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(1, 3);
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_byte_address <= addr;
        i_write_byte   <= data;
        in_raised = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_word(cmd, addr, data);
        burst_left--;
    endtask

    // Holds the sender off until every expected result word has arrived.
    // The task waits on the clock before it returns, so a following raise of valid falls
    // in a later time step than the lowering here.
    task automatic drain_results();
        if (in_raised) begin
            i_in_valid <= 1'b0;
            in_raised = 1'b0;
        end
        burst_left = 0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // Register writes only happen with the block idle: drained, and then a
    // settling wait for any write word still in the pipeline.
    task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        apply_register(idx, value);
    endtask

    task automatic send_shifts(input int count);
        for (int n = 0; n < count; n++) begin
            send_word(CMD_SHIFT, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // Reset geometry (quarter scan, 32x16): extreme writes, a write just off
    // the canvas, a swap with single buffering, an unknown command, and one
    // full scan line so the latch shows up.
    task automatic test_power_up_defaults();
        send_word(CMD_WRITE, 10'd0, 8'h00);
        send_word(CMD_WRITE, 10'd63, 8'hA5);
        send_word(CMD_WRITE, 10'd64, 8'h0F);
        send_word(CMD_SWAP, 10'd0, 8'h00);
        send_word(CMD_UNKNOWN, 10'h3FF, 8'hFF);
        send_shifts(16);
    endtask

    // Sixteenth scan on a one-byte-wide canvas: every shift latches, and the
    // output enable duty is the inverse of brightness.
    task automatic test_sixteenth_scan();
        write_register(CFG_PANEL_KIND, 8'd1);
        write_register(CFG_PANEL_WIDTH, 8'd8);
        write_register(CFG_PANEL_HEIGHT, 8'd16);
        write_register(CFG_BRIGHTNESS, 8'd0);
        send_word(CMD_WRITE, 10'd1, 8'h81);
        send_shifts(2);
    endtask

    // Saturating sizes give the largest canvas, which runs past the store;
    // zero sizes fall back to the defaults.
    task automatic test_size_extremes();
        write_register(CFG_PANELS_ACROSS, 8'd15);
        write_register(CFG_PANELS_DOWN, 8'd7);
        write_register(CFG_PANEL_WIDTH, 8'd200);
        write_register(CFG_PANEL_HEIGHT, 8'd127);
        write_register(CFG_BRIGHTNESS, 8'd255);
        send_word(CMD_WRITE, 10'd1023, 8'h00);
        send_shifts(1);
        write_register(CFG_PANEL_KIND, 8'd0);
        send_shifts(1);
        write_register(CFG_PANELS_ACROSS, 8'd0);
        write_register(CFG_PANELS_DOWN, 8'd0);
        write_register(CFG_PANEL_WIDTH, 8'd0);
        write_register(CFG_PANEL_HEIGHT, 8'd0);
        send_shifts(1);
    endtask

    // Double buffering: enabling clears store b and draws into it while the
    // other store is shown; a swap exchanges them; disabling returns to one.
    task automatic test_double_buffer();
        write_register(CFG_DOUBLE_BUFFER, 8'd1);
        write_register(CFG_DOUBLE_BUFFER, 8'd1);
        send_word(CMD_WRITE, 10'd48, 8'h3C);
        send_word(CMD_SWAP, 10'd0, 8'h00);
        send_shifts(1);
        write_register(CFG_DOUBLE_BUFFER, 8'd0);
    endtask

    // Picks a fresh register setting for one random phase. Mostly small
    // canvases so that scan lines complete often; now and then the extremes.
    task automatic choose_random_setting();
        int pick;
        write_register(CFG_PANEL_KIND, 8'($urandom_range(0, 1)));
        pick = $urandom_range(0, 9);
        write_register(CFG_PANELS_ACROSS, (pick < 8) ? 8'($urandom_range(1, 2))
                                                     : 8'($urandom_range(0, 15)));
        pick = $urandom_range(0, 9);
        write_register(CFG_PANELS_DOWN, (pick < 8) ? 8'($urandom_range(1, 2))
                                                   : 8'($urandom_range(0, 7)));
        pick = $urandom_range(0, 19);
        write_register(CFG_PANEL_WIDTH, (pick < 14) ? 8'($urandom_range(1, 40)) :
                                        (pick < 17) ? 8'd0 : 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 19);
        write_register(CFG_PANEL_HEIGHT, (pick < 14) ? 8'($urandom_range(1, 32)) :
                                         (pick < 17) ? 8'd0 : 8'($urandom_range(0, 127)));
        pick = $urandom_range(0, 9);
        write_register(CFG_BRIGHTNESS, (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255
                                                          : 8'($urandom_range(0, 255)));
        write_register(CFG_DOUBLE_BUFFER, 8'($urandom_range(0, 1)));
    endtask

    // Random phases: each picks a setting, then mixes pixel writes (mostly
    // on the canvas), shift steps, swaps and unknown commands.
    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int stride;
        int height;
        int canvas;
        int pick;
        logic [9:0] addr;
        logic [7:0] data;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            choose_random_setting();
            canvas_geometry(stride, height);
            canvas = (stride * height > FRAME_BYTES) ? FRAME_BYTES : stride * height;
            phase_len = $urandom_range(120, 260);
            for (int n = 0; n < phase_len; n++) begin
                // Now and then the sender waits for the pipeline to empty.
                if (n == phase_len / 2 && $urandom_range(0, 1) == 1) drain_results();
                pick = $urandom_range(0, 99);
                addr = (pick < 32) ? 10'($urandom_range(0, canvas - 1))
                                   : 10'($urandom_range(0, 1023));
                data = ($urandom_range(0, 7) == 0) ? {8{pick[0]}} : 8'($urandom_range(0, 255));
                if (pick < 40) send_word(CMD_WRITE, addr, data);
                else if (pick < 90) send_word(CMD_SHIFT, addr, data);
                else if (pick < 95) send_word(CMD_SWAP, addr, data);
                else send_word(CMD_UNKNOWN, addr, data);
            end
            sent += phase_len;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall modes, picked anew whenever the current mode runs out,
    // including stretches of constant ready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode   <= $urandom_range(0, 3);
            mode_left <= $urandom_range(64, 512);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= (cycle_count % 4) == 0;
            default: begin
                if (hold_left > 0) begin
                    hold_left <= hold_left - 1;
                end else begin
                    i_out_ready <= ~i_out_ready;
                    hold_left   <= $urandom_range(0, 15);
                end
            end
        endcase
    end

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            if (error_count <= REPORT_CAP) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        end
    endtask

    // Every accepted result word is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_word = {o_shift_byte, o_latch_now, o_row_address, o_oe_duty};
            if (expected_words.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_CAP) begin
                    $display("%0t: unexpected word, expected none actual %0h",
                             $time, got_word);
                end
            end else begin
                want_word = expected_words.pop_front();
                report_field("shift_byte", want_word.shift_byte, got_word.shift_byte);
                report_field("latch_now", want_word.latch_now, got_word.latch_now);
                report_field("row_address", want_word.row_address, got_word.row_address);
                report_field("oe_duty", want_word.oe_duty, got_word.oe_duty);
            end
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        reset_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The clearing pass after reset holds o_in_ready low; the input
        // handshakes below simply wait it out.
        test_power_up_defaults();
        test_sixteenth_scan();
        test_size_extremes();
        test_double_buffer();
        test_random_traffic();
        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
